/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int unsigned FIELD_BITS = 16;
    localparam int unsigned OCC_BITS   = 5;

    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] payload;
    } t_spq_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] out_key;
        logic [FIELD_BITS-1:0] out_payload;
        logic                  was_empty;
        logic                  was_full;
        logic [OCC_BITS-1:0]   occupancy;
    } t_spq_out;

    typedef struct packed {
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] payload;
    } t_spq_ent;

    typedef struct packed {
        logic     enq;
        logic     deq;
        t_spq_ent ent;
    } t_spq_cmd;

endpackage

/* hw/rtl/spq_cell.sv */
// One storage cell of the sorted queue row.
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  t_spq_cmd i_cmd,
    input  logic     i_occ,
    input  t_spq_ent i_left,
    input  logic     i_left_gt,
    input  t_spq_ent i_right,
    output t_spq_ent o_ent,
    output logic     o_gt
);

    t_spq_ent r_ent;
    t_spq_ent n_ent;

    assign o_ent = r_ent;
    assign o_gt  = !i_occ || (r_ent.key > i_cmd.ent.key);

    always_comb begin
        n_ent = r_ent;
        priority if (i_cmd.enq && o_gt) begin
            n_ent = i_left_gt ? i_left : i_cmd.ent;
        end else if (i_cmd.deq) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

/* hw/rtl/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: cell row, fill count and result register.
//
// Input channel i_in_valid / i_in_word / o_in_stall carries one operation word:
// kind selects enqueue or dequeue, key and payload describe the entry.
// Output channel o_out_valid / o_out_word / i_out_stall returns one result word
// per operation: the dequeued entry or zeros, the empty and full flags and the
// number of entries held afterwards.
// Every cell compares its key with the incoming key and takes its left or
// right neighbour's entry in the same cycle, so one operation is applied per
// cycle while o_in_stall is low: the result word is registered and o_out_valid
// rises in the cycle after acceptance, throughput one word per cycle. The result
// register lets a new word in while the previous result leaves in the same cycle.
// A stalled result holds in the register; the input stalls only while that
// register is full and the receiver stalls.
// Reset empties the queue (fill count zero) and clears o_out_valid; stored
// entries are not cleared and are never read until written.
// A full queue drops an enqueue and raises was_full; an empty queue answers
// a dequeue with was_empty. Equal keys leave in arrival order.
`timescale 1ns / 1ps

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH    = 16,
    parameter int unsigned KEY_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_spq_in  i_in_word,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_spq_out o_out_word,
    input  logic     i_out_stall
);

    localparam int unsigned KW = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [FIELD_BITS-1:0] KEY_MASK =
        FIELD_BITS'((33'd1 << KW) - 33'd1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_spq_out      r_out_word;
    t_spq_out      n_out_word;

    logic          accept;
    logic          full;
    logic          empty;
    t_spq_cmd      cmd;

    t_spq_ent      ents [DEPTH];
    logic          gts  [DEPTH];
    logic          occ  [DEPTH];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign full        = (r_count == CW'(DEPTH));
    assign empty       = (r_count == '0);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        cmd.enq         = accept && (i_in_word.kind == KIND_ENQ) && !full;
        cmd.deq         = accept && (i_in_word.kind == KIND_DEQ) && !empty;
        cmd.ent.key     = i_in_word.key & KEY_MASK;
        cmd.ent.payload = i_in_word.payload;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_spq_ent left;
        logic     left_gt;
        t_spq_ent right;

        assign occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_first
            assign left    = cmd.ent;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left    = ents[g-1];
            assign left_gt = gts[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = ents[g];
        end else begin : g_inner
            assign right = ents[g+1];
        end

        spq_cell u_cell (
            .i_clk    (i_clk),
            .i_cmd    (cmd),
            .i_occ    (occ[g]),
            .i_left   (left),
            .i_left_gt(left_gt),
            .i_right  (right),
            .o_ent    (ents[g]),
            .o_gt     (gts[g])
        );
    end

    always_comb begin
        n_count = r_count;
        priority if (cmd.enq) begin
            n_count = r_count + CW'(1);
        end else if (cmd.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_out_word             = '0;
        n_out_word.was_full    = (i_in_word.kind == KIND_ENQ) && full;
        n_out_word.was_empty   = (i_in_word.kind == KIND_DEQ) && empty;
        n_out_word.occupancy   = OCC_BITS'(n_count);
        if (cmd.deq) begin
            n_out_word.out_key     = ents[0].key;
            n_out_word.out_payload = ents[0].payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
